FILE: hw/rtl/wmp_pkg.sv
// Shared types and constants for the window maximum path block.
`default_nettype none
package wmp_pkg;

  localparam int SCORE_W = 32;
  localparam int VALUE_W = 16;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_RADIUS = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_CHECK    = 8'b0000_0100,
    ST_BACKRD   = 8'b0000_1000,
    ST_BACK     = 8'b0001_0000,
    ST_PUSH     = 8'b0010_0000,
    ST_FRONT    = 8'b0100_0000,
    ST_FRONTCHK = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic accept;
    logic seed;
    logic start_dq;
    logic rd_row;
    logic rd_back;
    logic pop_back;
    logic push;
    logic rd_front;
    logic pop_front;
    logic calc;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic row0;
    logic rebuild;
    logic more_push;
    logic dq_nonempty;
    logic back_dominated;
    logic front_stale;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wmp_ctrl.sv
// Controller state machine that sequences the deque and row store work per cell.
`default_nettype none
module wmp_ctrl
  import wmp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cell_valid,
  output logic      cell_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   pending, pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  assign cell_ready = (state == ST_IDLE) && !pending;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    pending_next = pending;
    case (state)
      ST_IDLE: begin
        if (pending) begin
          if (sts.out_free) begin
            cmd.write    = 1'b1;
            pending_next = 1'b0;
          end
        end else if (cell_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.row0) begin
          cmd.seed     = 1'b1;
          pending_next = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.start_dq = sts.rebuild;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.more_push) begin
          cmd.rd_row = 1'b1;
          state_next = ST_BACKRD;
        end else begin
          state_next = ST_FRONT;
        end
      end
      ST_BACKRD: begin
        if (sts.dq_nonempty) begin
          cmd.rd_back = 1'b1;
          state_next  = ST_BACK;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_BACK: begin
        if (sts.back_dominated) begin
          cmd.pop_back = 1'b1;
          state_next   = ST_BACKRD;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FRONT: begin
        cmd.rd_front = 1'b1;
        state_next   = ST_FRONTCHK;
      end
      ST_FRONTCHK: begin
        if (sts.front_stale) begin
          cmd.pop_front = 1'b1;
          state_next    = ST_FRONT;
        end else begin
          cmd.calc     = 1'b1;
          pending_next = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next   = ST_IDLE;
        pending_next = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/wmp_datapath.sv
// Datapath: row store banks, window deque, counters and the result register.
`default_nettype none
module wmp_datapath
  import wmp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IW-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data,
  input  wire logic signed [VALUE_W-1:0] cell_value,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic signed [SCORE_W-1:0]      path_score,
  output logic                           is_final,
  output logic signed [SCORE_W-1:0]      best_score,
  input  wire cmd_t                      cmd,
  output sts_t                           sts
);

  localparam int IW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int XW  = ((CW > 10) ? CW : 10) + 1;
  localparam logic signed [SCORE_W-1:0] MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

  logic [10:0] row_width;
  logic [7:0]  row_count;
  logic [9:0]  window_radius;
  logic        dq_ok;

  logic signed [SCORE_W-1:0] row_store [2][MAX_WIDTH];
  logic [IW+SCORE_W-1:0]     window_queue [MAX_WIDTH];
  logic signed [SCORE_W-1:0] rs_q;
  logic [IW+SCORE_W-1:0]     dq_q;

  logic [CW-1:0]  column_index, nxt, queue_head, queue_tail;
  logic [RIW-1:0] row_index;
  logic           bank_select;
  logic signed [SCORE_W-1:0] running_best, score;
  logic signed [VALUE_W-1:0] value_q;

  logic [CW-1:0]  w_eff, col_clip;
  logic [RCW-1:0] r_eff;
  logic [XW-1:0]  lo, hi, colx, rx, wm1;
  logic signed [SCORE_W-1:0] dq_val, best_next;
  logic [IW-1:0]  dq_idx;
  logic           top_row, last_col, fin;

  always_comb begin
    if (row_width == '0) begin
      w_eff = CW'(1);
    end else if (int'(row_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(row_width);
    end
    if (row_count == '0) begin
      r_eff = RCW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      r_eff = RCW'(MAX_ROWS);
    end else begin
      r_eff = RCW'(row_count);
    end
    col_clip = (column_index >= w_eff) ? w_eff - CW'(1) : column_index;
    colx     = XW'(column_index);
    rx       = XW'(window_radius);
    wm1      = XW'(w_eff) - XW'(1);
    lo       = (colx > rx) ? colx - rx : '0;
    hi       = ((colx + rx) > wm1) ? wm1 : colx + rx;
    dq_val   = dq_q[SCORE_W-1:0];
    dq_idx   = dq_q[IW+SCORE_W-1:SCORE_W];
    top_row  = RCW'(row_index) >= (r_eff - RCW'(1));
    last_col = column_index >= (w_eff - CW'(1));
    fin      = top_row && last_col;
    best_next = (top_row && (score > running_best)) ? score : running_best;
  end

  always_comb begin
    sts.row0           = (row_index == '0);
    sts.rebuild        = !dq_ok;
    sts.more_push      = XW'(nxt) <= hi;
    sts.dq_nonempty    = queue_tail != queue_head;
    sts.back_dominated = dq_val <= rs_q;
    sts.front_stale    = XW'(dq_idx) < lo;
    sts.out_free       = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_row) begin
      rs_q <= row_store[!bank_select][nxt[IW-1:0]];
    end
    if (cmd.write) begin
      row_store[bank_select][column_index[IW-1:0]] <= score;
    end
    if (cmd.rd_back || cmd.rd_front) begin
      dq_q <= window_queue[cmd.rd_back ? IW'(queue_tail - CW'(1)) : queue_head[IW-1:0]];
    end
    if (cmd.push) begin
      window_queue[queue_tail[IW-1:0]] <= {nxt[IW-1:0], rs_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_q <= cell_value;
    end
    if (cmd.seed) begin
      score <= SCORE_W'(value_q);
    end else if (cmd.calc) begin
      score <= dq_val + SCORE_W'(value_q);
    end
    if (cmd.write) begin
      path_score <= score;
      is_final   <= fin;
      best_score <= fin ? best_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= 11'd1024;
      row_count     <= 8'd128;
      window_radius <= 10'd1;
      dq_ok         <= 1'b0;
      column_index  <= '0;
      row_index     <= '0;
      bank_select   <= 1'b0;
      running_best  <= MOST_NEG;
      queue_head    <= '0;
      queue_tail    <= '0;
      nxt           <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_WIDTH:     row_width     <= cfg_data;
          CFG_ROW_COUNT:     row_count     <= cfg_data[7:0];
          CFG_WINDOW_RADIUS: window_radius <= cfg_data[9:0];
          default: ;
        endcase
        dq_ok <= 1'b0;
      end
      if (cmd.accept) begin
        column_index <= col_clip;
      end
      if (cmd.start_dq) begin
        queue_head <= '0;
        queue_tail <= '0;
        nxt        <= CW'(lo);
        dq_ok      <= 1'b1;
      end
      if (cmd.pop_back) begin
        queue_tail <= queue_tail - CW'(1);
      end
      if (cmd.push) begin
        queue_tail <= queue_tail + CW'(1);
        nxt        <= nxt + CW'(1);
      end
      if (cmd.pop_front) begin
        queue_head <= queue_head + CW'(1);
      end
      if (cmd.write) begin
        result_valid <= 1'b1;
        if (fin) begin
          column_index <= '0;
          row_index    <= '0;
          bank_select  <= 1'b0;
          running_best <= MOST_NEG;
          dq_ok        <= 1'b0;
        end else if (last_col) begin
          column_index <= '0;
          row_index    <= row_index + RIW'(1);
          bank_select  <= !bank_select;
          running_best <= best_next;
          dq_ok        <= 1'b0;
        end else begin
          column_index <= column_index + CW'(1);
          running_best <= best_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/window_max_path_dp.sv
// Top level of the streaming grid path scorer with a sliding-window maximum.
`default_nettype none
// Cells stream in bottom row first, left to right, one beat per cell, and each
// cell gives one result beat with its path score; the last cell of the top row
// also carries is_final and the top row's best score. Bottom-row cells go
// through the accept, the seed and the write of the output register. Other
// cells read each previous-row entry entering their window, drop the deque
// back entries that it dominates and push it, then drop stale entries from
// the deque front and add the front entry to the cell value. The first cell of
// a row above the bottom row, or the first such cell after a configuration
// write, rebuilds the deque over its whole window. A finished result waits in
// an output register while the next cell is taken; a result still waiting
// there holds back the next write and the next cell.
module window_max_path_dp
  import wmp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IW-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data,
  input  wire logic                      cell_valid,
  output logic                           cell_ready,
  input  wire logic signed [VALUE_W-1:0] cell_value,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic signed [SCORE_W-1:0]      path_score,
  output logic                           is_final,
  output logic signed [SCORE_W-1:0]      best_score
);

  cmd_t cmd;
  sts_t sts;

  wmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wmp_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_value   (cell_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .path_score   (path_score),
    .is_final     (is_final),
    .best_score   (best_score),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
`default_nettype wire
